@@ sv/rpn_pkg.sv @@
// Package: shared constants, operation codes, micro-op codes and status struct.
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_W          = 32;
  localparam int CMD_W           = 5;
  localparam int DEPTH_W         = 7;
  localparam int ERR_W           = 2;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ERR_W-1:0] err_t;

  localparam cmd_t CMD_PUSH  = 5'd0;
  localparam cmd_t CMD_ADD   = 5'd1;
  localparam cmd_t CMD_SUB   = 5'd2;
  localparam cmd_t CMD_MUL   = 5'd3;
  localparam cmd_t CMD_DIV   = 5'd4;
  localparam cmd_t CMD_MOD   = 5'd5;
  localparam cmd_t CMD_EQ    = 5'd6;
  localparam cmd_t CMD_GT    = 5'd7;
  localparam cmd_t CMD_LT    = 5'd8;
  localparam cmd_t CMD_LE    = 5'd9;
  localparam cmd_t CMD_GE    = 5'd10;
  localparam cmd_t CMD_NE    = 5'd11;
  localparam cmd_t CMD_POW   = 5'd12;
  localparam cmd_t CMD_MAX   = 5'd13;
  localparam cmd_t CMD_MIN   = 5'd14;
  localparam cmd_t CMD_ABS   = 5'd15;
  localparam cmd_t CMD_NEG   = 5'd16;
  localparam cmd_t CMD_DROP  = 5'd17;
  localparam cmd_t CMD_DUP   = 5'd18;
  localparam cmd_t CMD_SWAP  = 5'd19;
  localparam cmd_t CMD_SUM   = 5'd20;
  localparam cmd_t CMD_PROD  = 5'd21;
  localparam cmd_t CMD_DEPTH = 5'd22;
  localparam cmd_t CMD_REV   = 5'd23;
  localparam cmd_t CMD_GET   = 5'd24;
  localparam cmd_t CMD_PRINT = 5'd25;

  localparam err_t ERR_NONE  = 2'd0;
  localparam err_t ERR_UNDER = 2'd1;
  localparam err_t ERR_OVER  = 2'd2;
  localparam err_t ERR_DIVZ  = 2'd3;

  typedef logic [5:0] uop_t;

  localparam uop_t U_NOP       = 6'd0;
  localparam uop_t U_LATCH     = 6'd1;
  localparam uop_t U_PUSH      = 6'd2;
  localparam uop_t U_ERR1      = 6'd3;
  localparam uop_t U_ERR2      = 6'd4;
  localparam uop_t U_ERR3      = 6'd5;
  localparam uop_t U_RD_SP1    = 6'd6;
  localparam uop_t U_CAPB_RD2  = 6'd7;
  localparam uop_t U_CAPA      = 6'd8;
  localparam uop_t U_ALU       = 6'd9;
  localparam uop_t U_WR_ACC2   = 6'd10;
  localparam uop_t U_WR_A1     = 6'd11;
  localparam uop_t U_WR_B2     = 6'd12;
  localparam uop_t U_DIV_INIT  = 6'd13;
  localparam uop_t U_DIV_STEP  = 6'd14;
  localparam uop_t U_DIV_FIX   = 6'd15;
  localparam uop_t U_POW_INIT  = 6'd16;
  localparam uop_t U_POW_A     = 6'd17;
  localparam uop_t U_POW_B     = 6'd18;
  localparam uop_t U_WR_UN     = 6'd19;
  localparam uop_t U_DROP      = 6'd20;
  localparam uop_t U_DUP       = 6'd21;
  localparam uop_t U_SUM_INIT  = 6'd22;
  localparam uop_t U_RD_LO     = 6'd23;
  localparam uop_t U_SUM_ACC   = 6'd24;
  localparam uop_t U_SUM_WR    = 6'd25;
  localparam uop_t U_GET_INIT  = 6'd26;
  localparam uop_t U_CAPB      = 6'd27;
  localparam uop_t U_RD_LO1    = 6'd28;
  localparam uop_t U_GET_SHIFT = 6'd29;
  localparam uop_t U_GET_END   = 6'd30;
  localparam uop_t U_REV_INIT  = 6'd31;
  localparam uop_t U_REV_RDHI  = 6'd32;
  localparam uop_t U_REV_WLO   = 6'd33;
  localparam uop_t U_REV_WHI   = 6'd34;
  localparam uop_t U_PRINT     = 6'd35;
  localparam uop_t U_SHOW      = 6'd36;
  localparam uop_t U_OUT       = 6'd37;

  typedef struct packed {
    logic err_set;
    logic sp_lt1;
    logic sp_lt2;
    logic sp_full;
    logic b_zero;
    logic count_bad;
    logic idx_bad;
    logic lo_lt_hi;
    logic cnt_zero;
    logic e_zero;
    logic div_last;
    logic printed;
    logic out_free;
    cmd_t cmd;
  } stat_t;

endpackage

@@ sv/rpn_stack_alu.sv @@
// Top level: stack calculator, controller plus datapath with output register.
// Transactions are taken one at a time; no new one is taken until the last has been
//   handed to the output register, and a stalled result holds the next transaction at
//   its last step. Reset: synchronous rst empties the stack.
`timescale 1ns / 1ps
module rpn_stack_alu
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] literal,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     printed,
  output logic [DEPTH_W-1:0]       depth,
  output logic [ERR_W-1:0]         error_code
);

  // Status flows up to the controller, one micro-op code flows down each cycle.
  stat_t stat;
  uop_t  uop;

  // Controller: accept a transaction in idle, then step the datapath through the op.
  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .uop      (uop)
  );

  // Datapath: hold the stack, compute, and drive the result register, which frees
  // the controller to take the next transaction while a result waits downstream.
  // Reset clears the sticky error and the output register; stack memory keeps its contents.
  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .uop          (uop),
    .stat         (stat),
    .cmd          (cmd),
    .literal      (literal),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .printed      (printed),
    .depth        (depth),
    .error_code   (error_code)
  );

endmodule

@@ sv/rpn_ctrl.sv @@
// Controller: sequences micro-ops for each operation and drives the input stall.
`timescale 1ns / 1ps
module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output uop_t  uop
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_BIN0   = 5'd2;
  localparam logic [4:0] S_BIN1   = 5'd3;
  localparam logic [4:0] S_BIN2   = 5'd4;
  localparam logic [4:0] S_EXEC   = 5'd5;
  localparam logic [4:0] S_WR2    = 5'd6;
  localparam logic [4:0] S_DIV    = 5'd7;
  localparam logic [4:0] S_DIVFIX = 5'd8;
  localparam logic [4:0] S_POWA   = 5'd9;
  localparam logic [4:0] S_POWB   = 5'd10;
  localparam logic [4:0] S_SW1    = 5'd11;
  localparam logic [4:0] S_UN0    = 5'd12;
  localparam logic [4:0] S_UN1    = 5'd13;
  localparam logic [4:0] S_UN2    = 5'd14;
  localparam logic [4:0] S_SUMRD  = 5'd15;
  localparam logic [4:0] S_SUMACC = 5'd16;
  localparam logic [4:0] S_SUMWR  = 5'd17;
  localparam logic [4:0] S_GET1   = 5'd18;
  localparam logic [4:0] S_GETRD  = 5'd19;
  localparam logic [4:0] S_GETWR  = 5'd20;
  localparam logic [4:0] S_GETEND = 5'd21;
  localparam logic [4:0] S_REVA   = 5'd22;
  localparam logic [4:0] S_REVB   = 5'd23;
  localparam logic [4:0] S_REVC   = 5'd24;
  localparam logic [4:0] S_REVD   = 5'd25;
  localparam logic [4:0] S_FIN    = 5'd26;
  localparam logic [4:0] S_FIN1   = 5'd27;
  localparam logic [4:0] S_DONE   = 5'd28;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    uop        = U_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          uop        = U_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_FIN;
        if (!stat.err_set) begin
          unique case (stat.cmd)
            CMD_PUSH, CMD_DEPTH: begin
              uop = stat.sp_full ? U_ERR2 : U_PUSH;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_EQ, CMD_GT, CMD_LT,
            CMD_LE, CMD_GE, CMD_NE, CMD_POW, CMD_MAX, CMD_MIN, CMD_SWAP: begin
              if (stat.sp_lt2) uop = U_ERR1;
              else             state_next = S_BIN0;
            end
            CMD_ABS, CMD_NEG, CMD_DROP, CMD_DUP, CMD_SUM, CMD_PROD, CMD_GET,
            CMD_PRINT: begin
              if (stat.sp_lt1) uop = U_ERR1;
              else             state_next = S_UN0;
            end
            CMD_REV: begin
              if (!stat.sp_lt2) begin
                uop        = U_REV_INIT;
                state_next = S_REVA;
              end
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_BIN0: begin
        uop        = U_RD_SP1;
        state_next = S_BIN1;
      end
      S_BIN1: begin
        uop        = U_CAPB_RD2;
        state_next = S_BIN2;
      end
      S_BIN2: begin
        uop        = U_CAPA;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (stat.cmd == CMD_SWAP) begin
          uop        = U_WR_A1;
          state_next = S_SW1;
        end else if (stat.cmd == CMD_DIV || stat.cmd == CMD_MOD) begin
          if (stat.b_zero) begin
            uop        = U_ERR3;
            state_next = S_FIN;
          end else begin
            uop        = U_DIV_INIT;
            state_next = S_DIV;
          end
        end else if (stat.cmd == CMD_POW) begin
          uop        = U_POW_INIT;
          state_next = S_POWA;
        end else begin
          uop        = U_ALU;
          state_next = S_WR2;
        end
      end
      S_WR2: begin
        uop        = U_WR_ACC2;
        state_next = S_FIN;
      end
      S_DIV: begin
        uop = U_DIV_STEP;
        if (stat.div_last) state_next = S_DIVFIX;
      end
      S_DIVFIX: begin
        uop        = U_DIV_FIX;
        state_next = S_WR2;
      end
      S_POWA: begin
        if (stat.e_zero) begin
          state_next = S_WR2;
        end else begin
          uop        = U_POW_A;
          state_next = S_POWB;
        end
      end
      S_POWB: begin
        uop        = U_POW_B;
        state_next = S_POWA;
      end
      S_SW1: begin
        uop        = U_WR_B2;
        state_next = S_FIN;
      end
      S_UN0: begin
        uop        = U_RD_SP1;
        state_next = S_UN1;
      end
      S_UN1: begin
        uop        = U_CAPA;
        state_next = S_UN2;
      end
      S_UN2: begin
        state_next = S_FIN;
        unique case (stat.cmd)
          CMD_ABS, CMD_NEG: uop = U_WR_UN;
          CMD_DROP:         uop = U_DROP;
          CMD_DUP:          uop = stat.sp_full ? U_ERR2 : U_DUP;
          CMD_SUM, CMD_PROD: begin
            if (stat.count_bad) begin
              uop = U_ERR1;
            end else begin
              uop        = U_SUM_INIT;
              state_next = S_SUMRD;
            end
          end
          CMD_GET: begin
            if (stat.idx_bad) begin
              uop = U_ERR1;
            end else begin
              uop        = U_GET_INIT;
              state_next = S_GET1;
            end
          end
          CMD_PRINT: uop = U_PRINT;
          default:   uop = U_NOP;
        endcase
      end
      S_SUMRD: begin
        if (stat.cnt_zero) begin
          state_next = S_SUMWR;
        end else begin
          uop        = U_RD_LO;
          state_next = S_SUMACC;
        end
      end
      S_SUMACC: begin
        uop        = U_SUM_ACC;
        state_next = S_SUMRD;
      end
      S_SUMWR: begin
        uop        = U_SUM_WR;
        state_next = S_FIN;
      end
      S_GET1: begin
        uop        = U_CAPB;
        state_next = S_GETRD;
      end
      S_GETRD: begin
        if (stat.lo_lt_hi) begin
          uop        = U_RD_LO1;
          state_next = S_GETWR;
        end else begin
          state_next = S_GETEND;
        end
      end
      S_GETWR: begin
        uop        = U_GET_SHIFT;
        state_next = S_GETRD;
      end
      S_GETEND: begin
        uop        = U_GET_END;
        state_next = S_FIN;
      end
      S_REVA: begin
        if (stat.lo_lt_hi) begin
          uop        = U_RD_LO;
          state_next = S_REVB;
        end else begin
          state_next = S_FIN;
        end
      end
      S_REVB: begin
        uop        = U_REV_RDHI;
        state_next = S_REVC;
      end
      S_REVC: begin
        uop        = U_REV_WLO;
        state_next = S_REVD;
      end
      S_REVD: begin
        uop        = U_REV_WHI;
        state_next = S_REVA;
      end
      S_FIN: begin
        if (stat.printed) begin
          state_next = S_DONE;
        end else begin
          uop        = U_RD_SP1;
          state_next = S_FIN1;
        end
      end
      S_FIN1: begin
        uop        = U_SHOW;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          uop        = U_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/rpn_dpath.sv @@
// Datapath: stack memory, operand registers, ALU, shared multiplier, divider, output register.
`timescale 1ns / 1ps
module rpn_dpath
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  uop_t                     uop,
  output stat_t                    stat,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] literal,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     printed,
  output logic [DEPTH_W-1:0]       depth,
  output logic [ERR_W-1:0]         error_code
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  cmd_t              cmd_q;
  logic [DATA_W-1:0] lit_q;
  logic [SW-1:0]     sp;
  err_t              err;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] e;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic [SW-1:0]     cnt;
  logic [DATA_W-1:0] dq;
  logic [DATA_W-1:0] dr;
  logic [DATA_W-1:0] dvs;
  logic [4:0]        dcnt;
  logic [DATA_W-1:0] shown;
  logic              prn;

  logic [SW-1:0]       sp_m1;
  logic [SW-1:0]       sp_m2;
  logic [DATA_W-1:0]   mul_x;
  logic [DATA_W-1:0]   mul_y;
  logic [2*DATA_W-1:0] mul_full;
  logic [DATA_W-1:0]   alu_res;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W:0]     trial;
  logic                out_free;

  assign sp_m1    = sp - SW'(1);
  assign sp_m2    = sp - SW'(2);
  assign out_free = !out_valid || !out_stall;

  assign stat.err_set   = (err != ERR_NONE);
  assign stat.sp_lt1    = (sp == '0);
  assign stat.sp_lt2    = (sp < SW'(2));
  assign stat.sp_full   = (sp == SW'(STACK_DEPTH));
  assign stat.b_zero    = (b == '0);
  assign stat.count_bad = a[DATA_W-1] || (a > DATA_W'(sp_m1));
  assign stat.idx_bad   = a[DATA_W-1] || (a >= DATA_W'(sp_m1));
  assign stat.lo_lt_hi  = (lo < hi);
  assign stat.cnt_zero  = (cnt == '0);
  assign stat.e_zero    = (e == '0);
  assign stat.div_last  = (dcnt == 5'd31);
  assign stat.printed   = prn;
  assign stat.out_free  = out_free;
  assign stat.cmd       = cmd_q;

  // Shared multiplier, low word only
  always_comb begin
    unique case (uop)
      U_POW_A:   begin mul_x = acc;  mul_y = base;  end
      U_POW_B:   begin mul_x = base; mul_y = base;  end
      U_SUM_ACC: begin mul_x = acc;  mul_y = rdata; end
      default:   begin mul_x = a;    mul_y = b;     end
    endcase
  end
  assign mul_full = mul_x * mul_y;

  always_comb begin
    unique case (cmd_q)
      CMD_ADD: alu_res = a + b;
      CMD_SUB: alu_res = a - b;
      CMD_MUL: alu_res = mul_full[DATA_W-1:0];
      CMD_EQ:  alu_res = DATA_W'(a == b);
      CMD_NE:  alu_res = DATA_W'(a != b);
      CMD_GT:  alu_res = DATA_W'($signed(a) > $signed(b));
      CMD_LT:  alu_res = DATA_W'($signed(a) < $signed(b));
      CMD_LE:  alu_res = DATA_W'($signed(a) <= $signed(b));
      CMD_GE:  alu_res = DATA_W'($signed(a) >= $signed(b));
      CMD_MAX: alu_res = ($signed(b) > $signed(a)) ? b : a;
      CMD_MIN: alu_res = ($signed(a) < $signed(b)) ? a : b;
      default: alu_res = '0;
    endcase
  end

  // One restoring division step on magnitudes
  assign rem_sh = {dr, dq[DATA_W-1]};
  assign trial  = rem_sh - {1'b0, dvs};

  always_comb begin
    unique case (uop)
      U_CAPB_RD2: raddr = AW'(sp_m2);
      U_RD_LO:    raddr = lo;
      U_RD_LO1:   raddr = lo + AW'(1);
      U_REV_RDHI: raddr = hi;
      U_GET_INIT: raddr = a[AW-1:0];
      default:    raddr = AW'(sp_m1);
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = AW'(sp_m1);
    wdata = a;
    unique case (uop)
      U_PUSH: begin
        waddr = AW'(sp);
        wdata = (cmd_q == CMD_PUSH) ? lit_q : DATA_W'(sp);
      end
      U_WR_ACC2: begin
        waddr = AW'(sp_m2);
        wdata = acc;
      end
      U_WR_A1: begin
        waddr = AW'(sp_m1);
        wdata = a;
      end
      U_WR_B2: begin
        waddr = AW'(sp_m2);
        wdata = b;
      end
      U_WR_UN: begin
        waddr = AW'(sp_m1);
        wdata = ((cmd_q == CMD_NEG) || a[DATA_W-1]) ? -a : a;
      end
      U_DUP: begin
        waddr = AW'(sp);
        wdata = a;
      end
      U_SUM_WR: begin
        waddr = AW'(sp_m1 - a[SW-1:0]);
        wdata = acc;
      end
      U_GET_SHIFT, U_REV_WLO: begin
        waddr = lo;
        wdata = rdata;
      end
      U_GET_END: begin
        waddr = hi;
        wdata = b;
      end
      U_REV_WHI: begin
        waddr = hi;
        wdata = a;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= '0;
      err          <= ERR_NONE;
      prn          <= 1'b0;
      out_valid    <= 1'b0;
      result_value <= '0;
      printed      <= 1'b0;
      depth        <= '0;
      error_code   <= ERR_NONE;
    end else begin
      if (uop == U_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (uop)
        U_LATCH: begin
          cmd_q <= cmd;
          lit_q <= literal;
          prn   <= 1'b0;
        end
        U_PUSH, U_DUP: sp <= sp + SW'(1);
        U_ERR1: err <= ERR_UNDER;
        U_ERR2: err <= ERR_OVER;
        U_ERR3: err <= ERR_DIVZ;
        U_CAPB_RD2, U_CAPB: b <= rdata;
        U_CAPA: a <= rdata;
        U_ALU: acc <= alu_res;
        U_WR_ACC2, U_DROP, U_GET_END: sp <= sp_m1;
        U_DIV_INIT: begin
          dq   <= a[DATA_W-1] ? -a : a;
          dvs  <= b[DATA_W-1] ? -b : b;
          dr   <= '0;
          dcnt <= '0;
        end
        U_DIV_STEP: begin
          if (!trial[DATA_W]) begin
            dr <= trial[DATA_W-1:0];
            dq <= {dq[DATA_W-2:0], 1'b1};
          end else begin
            dr <= rem_sh[DATA_W-1:0];
            dq <= {dq[DATA_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 5'd1;
        end
        U_DIV_FIX: begin
          if (cmd_q == CMD_MOD) acc <= a[DATA_W-1] ? -dr : dr;
          else                  acc <= (a[DATA_W-1] ^ b[DATA_W-1]) ? -dq : dq;
        end
        U_POW_INIT: begin
          acc  <= b[DATA_W-1] ? '0 : DATA_W'(1);
          e    <= b[DATA_W-1] ? '0 : b;
          base <= a;
        end
        U_POW_A: begin
          if (e[0]) acc <= mul_full[DATA_W-1:0];
        end
        U_POW_B: begin
          base <= mul_full[DATA_W-1:0];
          e    <= e >> 1;
        end
        U_SUM_INIT: begin
          acc <= (cmd_q == CMD_SUM) ? '0 : DATA_W'(1);
          cnt <= a[SW-1:0];
          lo  <= AW'(sp_m2);
        end
        U_SUM_ACC: begin
          acc <= (cmd_q == CMD_SUM) ? acc + rdata : mul_full[DATA_W-1:0];
          lo  <= lo - AW'(1);
          cnt <= cnt - SW'(1);
        end
        U_SUM_WR: sp <= sp - a[SW-1:0];
        U_GET_INIT: begin
          lo <= a[AW-1:0];
          hi <= AW'(sp_m2);
        end
        U_GET_SHIFT: lo <= lo + AW'(1);
        U_REV_INIT: begin
          lo <= '0;
          hi <= AW'(sp_m1);
        end
        U_REV_RDHI: a <= rdata;
        U_REV_WHI: begin
          lo <= lo + AW'(1);
          hi <= hi - AW'(1);
        end
        U_PRINT: begin
          shown <= a;
          prn   <= 1'b1;
          sp    <= sp_m1;
        end
        U_SHOW: shown <= (sp == '0) ? '0 : rdata;
        U_OUT: begin
          result_value <= shown;
          printed      <= prn;
          depth        <= DEPTH_W'(sp);
          error_code   <= err;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/rpn_chk.sv @@
// Checker: port-level assertions for the stack calculator, bound to the top level.
`timescale 1ns / 1ps
module rpn_chk
  import rpn_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [CMD_W-1:0]         cmd,
  input logic signed [DATA_W-1:0] literal,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] result_value,
  input logic                     printed,
  input logic [DEPTH_W-1:0]       depth,
  input logic [ERR_W-1:0]         error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value))
    else $error("stalled result dropped or changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    error_code != ERR_NONE |=> error_code != ERR_NONE)
    else $error("sticky error cleared without reset");

  a_print_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && printed |-> error_code == ERR_NONE)
    else $error("print reported with error set");

endmodule

bind rpn_stack_alu rpn_chk u_rpn_chk (.*);

@@ sim/tb_rpn_stack_alu.sv @@
// Testbench for the stack calculator: directed and random operations checked against a predictor.
`timescale 1ns / 1ps
module tb_rpn_stack_alu;
  import rpn_pkg::*;

  localparam int STK = STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [DATA_W-1:0]  value;
    logic               printed;
    logic [DEPTH_W-1:0] depth;
    logic [ERR_W-1:0]   err;
  } calc_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd = '0;
  logic signed [DATA_W-1:0] literal = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic                     printed;
  logic [DEPTH_W-1:0]       depth;
  logic [ERR_W-1:0]         error_code;

  // Predicted calculator state, advanced once per accepted transaction.
  logic [DATA_W-1:0] calc_stack [STK];
  int unsigned       calc_sp = 0;
  logic [ERR_W-1:0]  calc_err = ERR_NONE;

  calc_result_t expected_results [$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  cycle = 0;
  int unsigned  hold_until = 0;
  int unsigned  tx_pct = 0;
  int unsigned  rx_pct = 0;

  rpn_stack_alu uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .literal(literal),
    .out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
    .printed(printed), .depth(depth), .error_code(error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stall, or a forced hold-off window to back the block up.
  always @(posedge clk) begin
    out_stall <= (cycle < hold_until) || ($urandom_range(0, 99) < rx_pct);
  end

  function automatic logic signed_lt(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
    return $signed(x) < $signed(y);
  endfunction

  // Truncating divide on magnitudes so that no host trap can occur.
  function automatic logic [DATA_W-1:0] div_or_rem(logic [DATA_W-1:0] x,
                                                   logic [DATA_W-1:0] y, logic want_rem);
    logic [DATA_W-1:0] ux, uy, q, r;
    ux = x[DATA_W-1] ? -x : x;
    uy = y[DATA_W-1] ? -y : y;
    q = ux / uy;
    r = ux % uy;
    if (want_rem) return x[DATA_W-1] ? -r : r;
    return (x[DATA_W-1] ^ y[DATA_W-1]) ? -q : q;
  endfunction

  function automatic logic [DATA_W-1:0] int_power(logic [DATA_W-1:0] base,
                                                  logic [DATA_W-1:0] ex);
    logic [DATA_W-1:0] acc;
    acc = DATA_W'(1);
    if (ex[DATA_W-1]) return '0;
    while (ex != 0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // Apply one operation to the predicted stack and return the result it shows.
  function automatic calc_result_t calc_step(cmd_t c, logic [DATA_W-1:0] lit);
    calc_result_t res;
    int unsigned s, rest;
    logic [ERR_W-1:0] e;
    logic [DATA_W-1:0] a, b, r, n, v, t;
    s = calc_sp;
    e = ERR_NONE;
    res.printed = 1'b0;
    res.value = '0;
    if (calc_err == ERR_NONE) begin
      if (c == CMD_PUSH || c == CMD_DEPTH) begin
        if (s >= STK) e = ERR_OVER;
        else begin
          calc_stack[s] = (c == CMD_PUSH) ? lit : DATA_W'(s);
          s++;
        end
      end else if (c >= CMD_ADD && c <= CMD_MIN) begin
        if (s < 2) e = ERR_UNDER;
        else begin
          b = calc_stack[s-1];
          a = calc_stack[s-2];
          r = '0;
          case (c)
            CMD_ADD: r = a + b;
            CMD_SUB: r = a - b;
            CMD_MUL: r = a * b;
            CMD_DIV, CMD_MOD: begin
              if (b == 0) e = ERR_DIVZ;
              else r = div_or_rem(a, b, c == CMD_MOD);
            end
            CMD_EQ:  r = DATA_W'(a == b);
            CMD_GT:  r = DATA_W'(signed_lt(b, a));
            CMD_LT:  r = DATA_W'(signed_lt(a, b));
            CMD_LE:  r = DATA_W'(!signed_lt(b, a));
            CMD_GE:  r = DATA_W'(!signed_lt(a, b));
            CMD_NE:  r = DATA_W'(a != b);
            CMD_POW: r = int_power(a, b);
            CMD_MAX: r = signed_lt(b, a) ? a : b;
            default: r = signed_lt(a, b) ? a : b;
          endcase
          if (e == ERR_NONE) begin
            s--;
            calc_stack[s-1] = r;
          end
        end
      end else if (c >= CMD_ABS && c <= CMD_DUP) begin
        if (s < 1) e = ERR_UNDER;
        else begin
          a = calc_stack[s-1];
          if (c == CMD_ABS) calc_stack[s-1] = a[DATA_W-1] ? -a : a;
          else if (c == CMD_NEG) calc_stack[s-1] = -a;
          else if (c == CMD_DROP) s--;
          else if (s >= STK) e = ERR_OVER;
          else begin
            calc_stack[s] = a;
            s++;
          end
        end
      end else if (c == CMD_SWAP) begin
        if (s < 2) e = ERR_UNDER;
        else begin
          t = calc_stack[s-1];
          calc_stack[s-1] = calc_stack[s-2];
          calc_stack[s-2] = t;
        end
      end else if (c == CMD_SUM || c == CMD_PROD) begin
        if (s < 1) e = ERR_UNDER;
        else begin
          n = calc_stack[s-1];
          rest = s - 1;
          if (n[DATA_W-1] || n > rest) e = ERR_UNDER;
          else begin
            a = (c == CMD_SUM) ? '0 : DATA_W'(1);
            for (int i = 0; i < n; i++) begin
              v = calc_stack[rest-1-i];
              a = (c == CMD_SUM) ? a + v : a * v;
            end
            s = rest - n;
            calc_stack[s] = a;
            s++;
          end
        end
      end else if (c == CMD_REV) begin
        for (int i = 0; i < s / 2; i++) begin
          t = calc_stack[i];
          calc_stack[i] = calc_stack[s-1-i];
          calc_stack[s-1-i] = t;
        end
      end else if (c == CMD_GET) begin
        if (s < 1) e = ERR_UNDER;
        else begin
          n = calc_stack[s-1];
          rest = s - 1;
          if (n[DATA_W-1] || n >= rest) e = ERR_UNDER;
          else begin
            v = calc_stack[n];
            for (int i = n; i + 1 < rest; i++) calc_stack[i] = calc_stack[i+1];
            calc_stack[rest-1] = v;
            s = rest;
          end
        end
      end else if (c == CMD_PRINT) begin
        if (s < 1) e = ERR_UNDER;
        else begin
          s--;
          res.value = calc_stack[s];
          res.printed = 1'b1;
        end
      end
      if (e != ERR_NONE) calc_err = e;
      else calc_sp = s;
    end
    if (!res.printed) res.value = (calc_sp > 0) ? calc_stack[calc_sp-1] : '0;
    res.depth = DEPTH_W'(calc_sp);
    res.err = calc_err;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatches++;
    $display("MISMATCH t=%0t %s: got %0h expected %0h", $time, what, got, want);
  endtask

  // Check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    calc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (result_value !== want.value) report_mismatch("result_value", result_value, want.value);
        if (printed !== want.printed)
          report_mismatch("printed", DATA_W'(printed), DATA_W'(want.printed));
        if (depth !== want.depth)
          report_mismatch("depth", DATA_W'(depth), DATA_W'(want.depth));
        if (error_code !== want.err)
          report_mismatch("error_code", DATA_W'(error_code), DATA_W'(want.err));
      end
    end
  end

  // Offer one transaction, idle first at random, and record its prediction on acceptance.
  task automatic send_item(cmd_t c, logic [DATA_W-1:0] lit);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    literal <= lit;
    do @(posedge clk); while (in_stall);
    expected_results.insert(expected_results.size(), calc_step(c, lit));
    items_sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_literal();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
      default: return DATA_W'($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  // True when the operation cannot raise an error on the predicted stack.
  function automatic logic op_is_safe(cmd_t c);
    if (c > CMD_PRINT) return 1'b1;
    case (c)
      CMD_PUSH, CMD_DEPTH: return calc_sp < STK;
      CMD_DUP: return calc_sp >= 1 && calc_sp < STK;
      CMD_DIV, CMD_MOD: return calc_sp >= 2 && calc_stack[calc_sp-1] != 0;
      CMD_ABS, CMD_NEG, CMD_DROP, CMD_PRINT: return calc_sp >= 1;
      CMD_REV: return 1'b1;
      CMD_SUM, CMD_PROD, CMD_GET: return 1'b0;
      default: return calc_sp >= 2;
    endcase
  endfunction

  task automatic test_directed();
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_PUSH, 32'hffff_ffff);
    send_item(CMD_DIV, 0);             // most negative over minus one
    send_item(CMD_ABS, 0);
    send_item(CMD_NEG, 0);
    send_item(CMD_PUSH, 32'hffff_ffff);
    send_item(CMD_MOD, 0);             // remainder of that case is zero
    send_item(CMD_PUSH, 32'h0);
    send_item(CMD_POW, 0);             // zero to the zero
    send_item(CMD_PUSH, 32'hffff_fffd);
    send_item(CMD_POW, 0);             // negative exponent
    send_item(CMD_PUSH, 32'h7fff_ffff);
    send_item(CMD_PUSH, 0);
    send_item(CMD_SUM, 0);             // empty sum
    send_item(CMD_PUSH, 0);
    send_item(CMD_PROD, 0);            // empty product
    send_item(CMD_DEPTH, 0);
    send_item(CMD_REV, 0);
    send_item(CMD_PUSH, 1);
    send_item(CMD_GET, 0);
    send_item(cmd_t'(5'd31), 32'h1234_5678);
    send_item(CMD_PRINT, 0);
  endtask

  // Walk the stack to its full depth, rearrange it there, then shrink it.
  task automatic test_full_stack();
    while (calc_sp < STK - 1) send_item(CMD_PUSH, pick_literal());
    send_item(CMD_DUP, 0);
    send_item(CMD_REV, 0);
    send_item(CMD_DROP, 0);
    send_item(CMD_PUSH, 0);
    send_item(CMD_GET, 0);
    send_item(CMD_PUSH, STK - 2);
    send_item(CMD_SUM, 0);
    while (calc_sp > 6) send_item(CMD_PRINT, 0);
  endtask

  task automatic random_item();
    cmd_t c;
    int unsigned lim;
    c = cmd_t'($urandom_range(0, 31));
    if (calc_sp < 3 || ($urandom_range(0, 99) < 15 && calc_sp < STK - 8)) begin
      send_item(CMD_PUSH, pick_literal());
    end else if (calc_sp > STK - 8) begin
      send_item($urandom_range(0, 1) ? CMD_DROP : CMD_PRINT, $urandom);
    end else if (c == CMD_SUM || c == CMD_PROD) begin
      lim = ($urandom_range(0, 9) == 0) ? calc_sp : ((calc_sp < 4) ? calc_sp : 4);
      send_item(CMD_PUSH, $urandom_range(0, lim));
      send_item(c, $urandom);
    end else if (c == CMD_GET) begin
      send_item(CMD_PUSH, $urandom_range(0, calc_sp - 1));
      send_item(c, $urandom);
    end else if (op_is_safe(c)) begin
      send_item(c, (c == CMD_PUSH) ? pick_literal() : $urandom);
    end else begin
      send_item(CMD_PUSH, DATA_W'($urandom_range(1, 9)));
    end
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) random_item();
  endtask

  // Hold the receiver off while the sender keeps offering work.
  task automatic test_backpressure();
    hold_until = cycle + 400;
    repeat (30) random_item();
  endtask

  // Latch one kind of sticky error, then show later transactions are ignored.
  task automatic test_error_lockout();
    case ($urandom_range(0, 2))
      0: begin
        while (calc_sp > 0) send_item(CMD_DROP, 0);
        send_item(CMD_PRINT, 0);
      end
      1: begin
        while (calc_sp < STK) send_item(CMD_PUSH, pick_literal());
        send_item(CMD_DEPTH, 0);
      end
      default: begin
        send_item(CMD_PUSH, 7);
        send_item(CMD_PUSH, 0);
        send_item(CMD_MOD, 0);
      end
    endcase
    repeat (6) send_item(cmd_t'($urandom_range(0, 31)), $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_pct = 29;
    rx_pct = 53;
    test_directed();
    test_random(70);
    test_full_stack();
    tx_pct = 53;
    rx_pct = 29;
    test_backpressure();
    test_random(60);
    tx_pct = 0;
    rx_pct = 0;
    test_random(60);
    test_error_lockout();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered all operations, full and empty stack, back-pressure and error lockout;");
    $display("%0d transactions sent, %0d results checked, %0d mismatches.",
             items_sent, results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
